FILE: src/cdq_pkg.sv
// Shared constants, command codes and transfer types for the circular deque.
package cdq_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int WORD_W      = 32;
   localparam int CSR_W       = 7;

   localparam logic [CSR_W-1:0] CAPACITY_RESET = 7'd64;
   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_QUERY      = 3'd4;

   typedef struct packed {
      logic [2:0]               command;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     success;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // Outcome of one command as seen by the datapath around the ring memory.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] front_addr;
      logic [IDX_W-1:0] rear_addr;
      logic             success;
      logic             empty;
      logic             full;
   } ctrl_type;

endpackage

FILE: src/cdq_ram.sv
// Ring memory: one write port and two registered read ports.
module cdq_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

FILE: src/cdq_ctrl.sv
// Capacity register, head pointer and entry count with the ring index arithmetic.
module cdq_ctrl import cdq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             accept,
   input  req_type          req,
   output ctrl_type         ctl
);

   logic [CSR_W-1:0] cap_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [CNT_W-1:0] eff_cap;
   logic [IDX_W-1:0] cap_m1;
   logic [IDX_W-1:0] head_dec, head_inc, back_pos;
   logic [CNT_W:0]   back_sum, rear_sum, cap_ext;
   logic             can_push, can_pop;

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(cap_ff) > MAX_ENTRIES) begin
         eff_cap = CNT_W'(MAX_ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign cap_m1   = IDX_W'(eff_cap - CNT_W'(1));
   assign cap_ext  = {1'b0, eff_cap};
   assign can_push = (count_ff < eff_cap);
   assign can_pop  = (count_ff != '0);
   assign head_dec = (head_ff == '0) ? cap_m1 : head_ff - IDX_W'(1);
   assign head_inc = (head_ff == cap_m1) ? '0 : head_ff + IDX_W'(1);

   // The back slot is head plus count, which stays below twice the capacity.
   assign back_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign back_pos = (back_sum >= cap_ext) ? IDX_W'(back_sum - cap_ext) : IDX_W'(back_sum);

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      ctl.wr_en   = 1'b0;
      ctl.wr_addr = back_pos;
      ctl.success = 1'b0;
      case (req.command)
         CMD_PUSH_FRONT: begin
            ctl.wr_addr = head_dec;
            if (can_push) begin
               head_in     = head_dec;
               count_in    = count_ff + CNT_W'(1);
               ctl.wr_en   = 1'b1;
               ctl.success = 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (can_push) begin
               count_in    = count_ff + CNT_W'(1);
               ctl.wr_en   = 1'b1;
               ctl.success = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (can_pop) begin
               head_in     = head_inc;
               count_in    = count_ff - CNT_W'(1);
               ctl.success = 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (can_pop) begin
               count_in    = count_ff - CNT_W'(1);
               ctl.success = 1'b1;
            end
         end
         CMD_QUERY: begin
            ctl.success = 1'b1;
         end
         default: begin
            ctl.success = 1'b0;
         end
      endcase

      // The rear address only matters when the queue is not empty afterwards.
      rear_sum       = (CNT_W+1)'(head_in) + (CNT_W+1)'(count_in) - (CNT_W+1)'(1);
      ctl.front_addr = head_in;
      ctl.rear_addr  = (rear_sum >= cap_ext) ? IDX_W'(rear_sum - cap_ext)
                                             : IDX_W'(rear_sum);
      ctl.empty      = (count_in == '0);
      ctl.full       = (count_in == eff_cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAPACITY_RESET;
         head_ff  <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         cap_ff   <= csr_wdata;
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= eff_cap)
      else $error("entry count exceeds the effective capacity");

   a_head_bounded: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(head_ff) < eff_cap)
      else $error("head index outside the ring");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we && ctl.wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("a successful push did not add one entry");

endmodule

FILE: src/circular_deque.sv
// Top level of the circular deque: handshakes, ring memory and result register.
// Each accepted item is read from the ring memory and its result is then loaded into the output register.
// req_stall stays high while a memory read is pending, until its result is loaded into the output register.
// A finished result waits in the output register while the next item is accepted.
// Synchronous active-high reset empties the queue and sets the capacity to 64.
// A capacity write also empties the queue; the memory contents are never cleared.
module circular_deque import cdq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic     state_ff, state_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   logic     accept, load_rsp;
   ctrl_type ctl;

   logic              succ_ff, empty_ff, full_ff, fwd_front_ff, fwd_rear_ff;
   logic [WORD_W-1:0] value_ff;
   logic [WORD_W-1:0] rd_front, rd_rear;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_rsp  = (state_ff == ST_READ) && (!rsp_valid_ff || !rsp_stall);

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req       (req_data),
      .ctl       (ctl)
   );

   cdq_ram #(
      .DEPTH  (MAX_ENTRIES),
      .WIDTH  (WORD_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (accept && ctl.wr_en),
      .wr_addr   (ctl.wr_addr),
      .wr_data   (req_data.value),
      .rd_en     (accept),
      .rd_addr_a (ctl.front_addr),
      .rd_addr_b (ctl.rear_addr),
      .rd_data_a (rd_front),
      .rd_data_b (rd_rear)
   );

   // The memory reads the old word when it is written in the same cycle, so a pushed
   // word that lands on an end of the queue is forwarded from the captured request.
   always_ff @(posedge clock) begin
      if (accept) begin
         succ_ff      <= ctl.success;
         empty_ff     <= ctl.empty;
         full_ff      <= ctl.full;
         fwd_front_ff <= ctl.wr_en && (ctl.wr_addr == ctl.front_addr);
         fwd_rear_ff  <= ctl.wr_en && (ctl.wr_addr == ctl.rear_addr);
         value_ff     <= req_data.value;
      end
   end

   always_comb begin
      rsp_data_in.success  = succ_ff;
      rsp_data_in.is_empty = empty_ff;
      rsp_data_in.is_full  = full_ff;
      if (empty_ff) begin
         rsp_data_in.front_value = EMPTY_WORD;
         rsp_data_in.rear_value  = EMPTY_WORD;
      end else begin
         rsp_data_in.front_value = fwd_front_ff ? value_ff : rd_front;
         rsp_data_in.rear_value  = fwd_rear_ff  ? value_ff : rd_rear;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted transfer did not start a memory read");

   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.is_empty |->
         rsp_data_ff.front_value == EMPTY_WORD && rsp_data_ff.rear_value == EMPTY_WORD)
      else $error("empty queue reported a stored word");

   a_empty_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.is_empty && rsp_data_ff.is_full))
      else $error("queue reported both empty and full");

endmodule
